// ----- hdl/segment_closest_point_macros.svh -----
// Assertion macros shared by the closest point block.
// Both expect clk and arst_n in the scope where they are used.
`ifndef SEGMENT_CLOSEST_POINT_MACROS_SVH
`define SEGMENT_CLOSEST_POINT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define SCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition never occurs outside reset
`define SCP_NEVER(lbl, cond, msg) \
	`SCP_ASSERT(lbl, !(cond), msg)

`else

`define SCP_ASSERT(lbl, prop, msg)
`define SCP_NEVER(lbl, cond, msg)

`endif

`endif

// ----- hdl/scp_pkg.sv -----
`default_nettype none

package scp_pkg;

	// queue geometry, shared by both queues
	localparam int QDepth = 128;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCw    = QAw + 1;

	// arithmetic widths
	localparam int DotW = 67;   // signed dot product, Q32.32
	localparam int LenW = 66;   // squared length and dot magnitude
	localparam int RemW = 98;   // divider remainder

	localparam logic [31:0] OneQ16 = 32'h0001_0000;
	localparam logic [31:0] MaxS32 = 32'h7FFF_FFFF;
	localparam logic [31:0] MinS32 = 32'h8000_0000;

	// request classes decided by the front end
	localparam logic [1:0] KindA   = 2'd0;  // point A, t = 0
	localparam logic [1:0] KindB   = 2'd1;  // point B, t = 1.0
	localparam logic [1:0] KindDiv = 2'd2;  // t from division

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0][32:0] ab;
		logic [2:0][31:0] p;
	} geo_t;

	typedef struct packed {
		geo_t            geo;
		logic [LenW-1:0] dmag;
		logic [LenW-1:0] len2;
		logic [1:0]      kind;
		logic            dneg;
		logic            degen;
	} mid_t;

	typedef struct packed {
		logic [2:0][31:0] c;
		logic [31:0]      t;
		logic [31:0]      distance;
		logic             degen;
	} res_t;

	typedef struct packed {
		logic            full;
		logic            empty;
		logic            wr_en;
		logic [QAw-1:0]  wr_addr;
		logic            rd_en;
		logic [QAw-1:0]  rd_addr;
	} qctl_t;

endpackage

`default_nettype wire

// ----- hdl/segment_closest_point.sv -----
`default_nettype none

// Closest point on a 3D segment (clamp_mode 1) or infinite line
// (clamp_mode 0) to a query point, signed Q16.16, with the parameter t,
// the unsigned Q16.16 distance and a zero-length segment flag. Requests go into
// a queue-like input and results come from a queue-like output, one request
// per clock in both directions while full is low and the consumer pops. A
// request passes the front end (differences, products, sums, class), the
// request queue, then the back end, whose depth is set mostly by the
// 31-stage restoring divider for t and the 32-stage square root for the
// distance. Each queue holds 128 requests; full rises only when 128
// requests are in flight ahead of a stalled consumer. Write clamp_mode
// only while no request is in flight.
module segment_closest_point (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	output logic                    empty,
	input  wire logic               pop,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data,
	input  wire logic signed [31:0] a_x,
	input  wire logic signed [31:0] a_y,
	input  wire logic signed [31:0] a_z,
	input  wire logic signed [31:0] b_x,
	input  wire logic signed [31:0] b_y,
	input  wire logic signed [31:0] b_z,
	input  wire logic signed [31:0] p_x,
	input  wire logic signed [31:0] p_y,
	input  wire logic signed [31:0] p_z,
	output logic signed [31:0]      c_x,
	output logic signed [31:0]      c_y,
	output logic signed [31:0]      c_z,
	output logic signed [31:0]      param_t,
	output logic        [31:0]      distance,
	output logic                    degenerate
);

	logic             clamp_mode_q;
	logic             accept;
	logic             front_vld;
	scp_pkg::mid_t    front_rec;
	scp_pkg::mid_t    mid_rd;
	scp_pkg::qctl_t   mid_ctl;
	logic             mid_pop;
	logic             back_vld;
	scp_pkg::res_t    back_rec;
	scp_pkg::res_t    out_rd;
	scp_pkg::qctl_t   out_ctl;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			clamp_mode_q <= cfg_data;
		end
	end

	assign full   = mid_ctl.full;
	assign accept = push && !full;

	scp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.clamp_mode (clamp_mode_q),
		.a_x        (a_x),
		.a_y        (a_y),
		.a_z        (a_z),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.p_x        (p_x),
		.p_y        (p_y),
		.p_z        (p_z),
		.out_vld    (front_vld),
		.out_rec    (front_rec)
	);

	// request queue between front and back
	scp_qctl u_mid_qctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.reserve (accept),
		.wr      (front_vld),
		.pop     (mid_pop),
		.ctl     (mid_ctl)
	);

	scp_ram #(
		.Width ($bits(scp_pkg::mid_t)),
		.Depth (scp_pkg::QDepth)
	) u_mid_ram (
		.clk     (clk),
		.wr_en   (mid_ctl.wr_en),
		.wr_addr (mid_ctl.wr_addr),
		.wr_data (front_rec),
		.rd_en   (mid_ctl.rd_en),
		.rd_addr (mid_ctl.rd_addr),
		.rd_data (mid_rd)
	);

	// back end takes a request when the result queue has room for it
	assign mid_pop = !mid_ctl.empty && !out_ctl.full;

	scp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (mid_pop),
		.in_rec  (mid_rd),
		.out_vld (back_vld),
		.out_rec (back_rec)
	);

	// result queue
	scp_qctl u_out_qctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.reserve (mid_pop),
		.wr      (back_vld),
		.pop     (pop),
		.ctl     (out_ctl)
	);

	scp_ram #(
		.Width ($bits(scp_pkg::res_t)),
		.Depth (scp_pkg::QDepth)
	) u_out_ram (
		.clk     (clk),
		.wr_en   (out_ctl.wr_en),
		.wr_addr (out_ctl.wr_addr),
		.wr_data (back_rec),
		.rd_en   (out_ctl.rd_en),
		.rd_addr (out_ctl.rd_addr),
		.rd_data (out_rd)
	);

	assign empty      = out_ctl.empty;
	assign c_x        = out_rd.c[0];
	assign c_y        = out_rd.c[1];
	assign c_z        = out_rd.c[2];
	assign param_t    = out_rd.t;
	assign distance   = out_rd.distance;
	assign degenerate = out_rd.degen;

endmodule

`default_nettype wire

// ----- hdl/scp_ram.sv -----
`default_nettype none

// simple dual port RAM, registered read data held while rd_en is low
module scp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	parameter int Aw    = $clog2(Depth)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [Aw-1:0]    wr_addr,
	input  wire logic [Width-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [Aw-1:0]    rd_addr,
	output logic      [Width-1:0] rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/scp_qctl.sv -----
`default_nettype none

`include "segment_closest_point_macros.svh"

// Queue control with reservations: a slot is reserved when a request
// enters the pipeline feeding the queue and released when it is popped,
// so the pipeline itself never has to stall.
module scp_qctl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          reserve,
	input  wire logic          wr,
	input  wire logic          pop,
	output scp_pkg::qctl_t     ctl
);

	logic [scp_pkg::QCw-1:0] resv_q;
	logic [scp_pkg::QCw-1:0] mem_cnt_q;
	logic [scp_pkg::QAw-1:0] wr_ptr_q;
	logic [scp_pkg::QAw-1:0] rd_ptr_q;
	logic                    out_vld_q;
	logic                    rel;
	logic                    load;

	// head register refills from memory whenever it is free or leaving
	assign rel  = pop && out_vld_q;
	assign load = (mem_cnt_q != '0) && (!out_vld_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q    <= '0;
			mem_cnt_q <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			resv_q    <= resv_q + scp_pkg::QCw'(reserve) - scp_pkg::QCw'(rel);
			mem_cnt_q <= mem_cnt_q + scp_pkg::QCw'(wr) - scp_pkg::QCw'(load);
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctl.full    = (resv_q == scp_pkg::QCw'(scp_pkg::QDepth));
		ctl.empty   = !out_vld_q;
		ctl.wr_en   = wr;
		ctl.wr_addr = wr_ptr_q;
		ctl.rd_en   = load;
		ctl.rd_addr = rd_ptr_q;
	end

	`SCP_ASSERT(a_resv_bound, resv_q <= scp_pkg::QCw'(scp_pkg::QDepth), "reservations exceed depth")
	`SCP_ASSERT(a_held_covered, (mem_cnt_q + scp_pkg::QCw'(out_vld_q)) <= resv_q, "held entries not reserved")
	`SCP_NEVER(a_no_overflow, wr && !load && mem_cnt_q == scp_pkg::QCw'(scp_pkg::QDepth), "write to full memory")

endmodule

`default_nettype wire

// ----- hdl/scp_front.sv -----
`default_nettype none

// Front end: differences, dot product and squared length, then class.
module scp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic               clamp_mode,
	input  wire logic signed [31:0] a_x,
	input  wire logic signed [31:0] a_y,
	input  wire logic signed [31:0] a_z,
	input  wire logic signed [31:0] b_x,
	input  wire logic signed [31:0] b_y,
	input  wire logic signed [31:0] b_z,
	input  wire logic signed [31:0] p_x,
	input  wire logic signed [31:0] p_y,
	input  wire logic signed [31:0] p_z,
	output logic                    out_vld,
	output scp_pkg::mid_t           out_rec
);

	logic [2:0][31:0] a_in;
	logic [2:0][31:0] b_in;
	logic [2:0][31:0] p_in;

	logic                        vld_s1, vld_s2, vld_s3;
	scp_pkg::geo_t               geo_s1, geo_s2, geo_s3;
	logic [2:0][32:0]            ap_s1;
	logic signed [65:0]          dotp_s2 [3];
	logic signed [65:0]          sqp_s2  [3];
	logic signed [scp_pkg::DotW-1:0] dot_s3;
	logic [scp_pkg::LenW-1:0]    len2_s3;

	logic                        dneg;
	logic [scp_pkg::LenW-1:0]    dmag;
	logic                        degen;
	logic [1:0]                  kind;

	assign a_in = {a_z, a_y, a_x};
	assign b_in = {b_z, b_y, b_x};
	assign p_in = {p_z, p_y, p_x};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	// stage 1: exact differences B-A and P-A
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			geo_s1.ab[i] <= {b_in[i][31], b_in[i]} - {a_in[i][31], a_in[i]};
			ap_s1[i]     <= {p_in[i][31], p_in[i]} - {a_in[i][31], a_in[i]};
		end
		geo_s1.a <= a_in;
		geo_s1.p <= p_in;
	end

	// stage 2: per axis products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dotp_s2[i] <= $signed(geo_s1.ab[i]) * $signed(ap_s1[i]);
			sqp_s2[i]  <= $signed(geo_s1.ab[i]) * $signed(geo_s1.ab[i]);
		end
		geo_s2 <= geo_s1;
	end

	// stage 3: dot product and squared length
	always_ff @(posedge clk) begin
		dot_s3  <= scp_pkg::DotW'(dotp_s2[0]) + scp_pkg::DotW'(dotp_s2[1])
			+ scp_pkg::DotW'(dotp_s2[2]);
		len2_s3 <= $unsigned(sqp_s2[0]) + $unsigned(sqp_s2[1]) + $unsigned(sqp_s2[2]);
		geo_s3  <= geo_s2;
	end

	// classification
	always_comb begin
		dneg  = dot_s3[scp_pkg::DotW-1];
		dmag  = dneg ? scp_pkg::LenW'(-dot_s3) : scp_pkg::LenW'(dot_s3);
		degen = (len2_s3 == '0);
		if (degen) begin
			kind = scp_pkg::KindA;
		end else if (!clamp_mode) begin
			kind = scp_pkg::KindDiv;
		end else if (dneg || dmag == '0) begin
			kind = scp_pkg::KindA;
		end else if (dmag >= len2_s3) begin
			kind = scp_pkg::KindB;
		end else begin
			kind = scp_pkg::KindDiv;
		end
	end

	// stage 4: record for the queue
	always_ff @(posedge clk) begin
		out_rec.geo   <= geo_s3;
		out_rec.dmag  <= dmag;
		out_rec.len2  <= len2_s3;
		out_rec.kind  <= kind;
		out_rec.dneg  <= dneg;
		out_rec.degen <= degen;
	end

endmodule

`default_nettype wire

// ----- hdl/scp_back.sv -----
`default_nettype none

// Back end: pipelined divider, closest point, squared distance, root.
module scp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire scp_pkg::mid_t in_rec,
	output logic               out_vld,
	output scp_pkg::res_t      out_rec
);

	typedef struct packed {
		scp_pkg::geo_t                geo;
		logic [scp_pkg::LenW-1:0]     den;
		logic [scp_pkg::RemW-1:0]     rem;
		logic [30:0]                  q;
		logic                         cap;
		logic [1:0]                   kind;
		logic                         dneg;
		logic                         degen;
	} div_t;

	typedef struct packed {
		logic [2:0][31:0] c;
		logic [31:0]      t;
		logic             degen;
		logic [63:0]      x;
		logic [63:0]      res;
		logic             hi;
	} sq_t;

	localparam int DivN = 31;
	localparam int SqN  = 32;

	div_t             div_s   [DivN+1];
	logic             div_vld [DivN+1];
	sq_t              sq_s    [SqN+1];
	logic             sq_vld  [SqN+1];

	logic             vld_t, vld_m, vld_c, vld_d;
	scp_pkg::geo_t    geo_t_s;
	logic [31:0]      t_t;
	logic             degen_t;
	logic [2:0][48:0] m_m;
	logic [2:0]       neg_m;
	logic [2:0][31:0] a_m, p_m, p_c;
	logic [31:0]      t_m, t_c, t_d;
	logic             degen_m, degen_c, degen_d;
	logic [2:0][31:0] c_c, c_d;
	logic [64:0]      sq_d [3];

	logic [31:0]      q32;
	logic [31:0]      t_new;

	// valid chain through the whole back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DivN; i++) begin
				div_vld[i] <= 1'b0;
			end
			for (int i = 0; i <= SqN; i++) begin
				sq_vld[i] <= 1'b0;
			end
			vld_t   <= 1'b0;
			vld_m   <= 1'b0;
			vld_c   <= 1'b0;
			vld_d   <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			div_vld[0] <= in_vld;
			for (int i = 0; i < DivN; i++) begin
				div_vld[i+1] <= div_vld[i];
			end
			vld_t     <= div_vld[DivN];
			vld_m     <= vld_t;
			vld_c     <= vld_m;
			vld_d     <= vld_c;
			sq_vld[0] <= vld_d;
			for (int i = 0; i < SqN; i++) begin
				sq_vld[i+1] <= sq_vld[i];
			end
			out_vld <= sq_vld[SqN];
		end
	end

	// divider entry: quotient cap at 2^31
	always_ff @(posedge clk) begin
		div_s[0].geo   <= in_rec.geo;
		div_s[0].den   <= in_rec.len2;
		div_s[0].rem   <= scp_pkg::RemW'(in_rec.dmag) << 16;
		div_s[0].q     <= '0;
		div_s[0].cap   <= (scp_pkg::RemW'(in_rec.dmag) << 16)
			>= (scp_pkg::RemW'(in_rec.len2) << 31);
		div_s[0].kind  <= in_rec.kind;
		div_s[0].dneg  <= in_rec.dneg;
		div_s[0].degen <= in_rec.degen;
	end

	// restoring divider, one quotient bit per stage
	for (genvar gi = 0; gi < DivN; gi++) begin : g_div
		localparam int Sh = DivN - 1 - gi;
		logic [scp_pkg::RemW-1:0] trial;
		assign trial = scp_pkg::RemW'(div_s[gi].den) << Sh;
		always_ff @(posedge clk) begin
			div_s[gi+1] <= div_s[gi];
			if (div_s[gi].rem >= trial) begin
				div_s[gi+1].rem   <= div_s[gi].rem - trial;
				div_s[gi+1].q[Sh] <= 1'b1;
			end
		end
	end

	// parameter from class and quotient
	always_comb begin
		q32 = div_s[DivN].cap ? scp_pkg::MinS32 : {1'b0, div_s[DivN].q};
		case (div_s[DivN].kind)
			scp_pkg::KindA: t_new = '0;
			scp_pkg::KindB: t_new = scp_pkg::OneQ16;
			scp_pkg::KindDiv: begin
				if (div_s[DivN].dneg) begin
					t_new = -q32;
				end else begin
					t_new = q32[31] ? scp_pkg::MaxS32 : q32;
				end
			end
			default: t_new = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		t_t     <= t_new;
		geo_t_s <= div_s[DivN].geo;
		degen_t <= div_s[DivN].degen;
	end

	// scaled direction, truncated toward zero
	always_ff @(posedge clk) begin
		logic [32:0] abmag;
		logic [31:0] tmag;
		logic [64:0] prod;
		for (int i = 0; i < 3; i++) begin
			abmag    = geo_t_s.ab[i][32] ? -geo_t_s.ab[i] : geo_t_s.ab[i];
			tmag     = t_t[31] ? -t_t : t_t;
			prod     = 65'(abmag) * 65'(tmag);
			m_m[i]   <= prod[64:16];
			neg_m[i] <= geo_t_s.ab[i][32] ^ t_t[31];
		end
		a_m     <= geo_t_s.a;
		p_m     <= geo_t_s.p;
		t_m     <= t_t;
		degen_m <= degen_t;
	end

	// closest point with saturation
	always_ff @(posedge clk) begin
		logic signed [50:0] sum;
		for (int i = 0; i < 3; i++) begin
			sum = 51'($signed(a_m[i])) + (neg_m[i] ? -51'(m_m[i]) : 51'(m_m[i]));
			if (sum > 51'sh7FFF_FFFF) begin
				c_c[i] <= scp_pkg::MaxS32;
			end else if (sum < -51'sh8000_0000) begin
				c_c[i] <= scp_pkg::MinS32;
			end else begin
				c_c[i] <= sum[31:0];
			end
		end
		p_c     <= p_m;
		t_c     <= t_m;
		degen_c <= degen_m;
	end

	// squared offsets from the query point
	always_ff @(posedge clk) begin
		logic signed [32:0] d;
		logic signed [65:0] sq;
		for (int i = 0; i < 3; i++) begin
			d       = $signed({p_c[i][31], p_c[i]}) - $signed({c_c[i][31], c_c[i]});
			sq      = d * d;
			sq_d[i] <= sq[64:0];
		end
		c_d     <= c_c;
		t_d     <= t_c;
		degen_d <= degen_c;
	end

	// sum of squares into the root pipeline
	always_ff @(posedge clk) begin
		logic [66:0] s;
		s = 67'(sq_d[0]) + 67'(sq_d[1]) + 67'(sq_d[2]);
		sq_s[0].c     <= c_d;
		sq_s[0].t     <= t_d;
		sq_s[0].degen <= degen_d;
		sq_s[0].x     <= s[63:0];
		sq_s[0].res   <= '0;
		sq_s[0].hi    <= (s[66:64] != '0);
	end

	// integer square root, one result bit per stage
	for (genvar gi = 0; gi < SqN; gi++) begin : g_sqrt
		localparam int Sh = 2 * (SqN - 1 - gi);
		logic [63:0] one_bit;
		logic [63:0] trial;
		assign one_bit = 64'(1) << Sh;
		assign trial   = sq_s[gi].res + one_bit;
		always_ff @(posedge clk) begin
			sq_s[gi+1] <= sq_s[gi];
			if (sq_s[gi].x >= trial) begin
				sq_s[gi+1].x   <= sq_s[gi].x - trial;
				sq_s[gi+1].res <= (sq_s[gi].res >> 1) + one_bit;
			end else begin
				sq_s[gi+1].res <= sq_s[gi].res >> 1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		out_rec.c        <= sq_s[SqN].c;
		out_rec.t        <= sq_s[SqN].t;
		out_rec.degen    <= sq_s[SqN].degen;
		out_rec.distance <= sq_s[SqN].hi ? 32'hFFFF_FFFF : sq_s[SqN].res[31:0];
	end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
module tb_top;

	typedef struct {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [31:0] t;
		logic [31:0] dst;
		logic        degen;
	} point_res_t;

	typedef struct {
		logic [31:0] f [9];
		logic        typed;
		point_res_t  e;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_data = 1'b0;
	logic [31:0] in_f [9];
	logic        full, empty, cfg_ready;
	logic signed [31:0] c_x, c_y, c_z, param_t;
	logic [31:0] distance;
	logic        degenerate;

	// state of the predictor and the scoreboard
	logic        seg_mode = 1'b1;
	logic        cur_typed = 1'b0;
	point_res_t  cur_exp;
	point_res_t  pending_q [$];
	int          in_cnt = 0;
	int          cfg_cnt = 0;
	int          errors = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	stim_row_t   rows [$];

	initial begin
		for (int i = 0; i < 9; i++) begin
			in_f[i] = '0;
		end
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_closest_point u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.empty      (empty),
		.pop        (pop),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.a_x        (in_f[0]),
		.a_y        (in_f[1]),
		.a_z        (in_f[2]),
		.b_x        (in_f[3]),
		.b_y        (in_f[4]),
		.b_z        (in_f[5]),
		.p_x        (in_f[6]),
		.p_y        (in_f[7]),
		.p_z        (in_f[8]),
		.c_x        (c_x),
		.c_y        (c_y),
		.c_z        (c_z),
		.param_t    (param_t),
		.distance   (distance),
		.degenerate (degenerate)
	);

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// trunc(d * t / 2^16)
	function automatic longint scale_q16(longint d, longint tt);
		longint unsigned m;
		m = (mag(d) * mag(tt)) >> 16;
		return ((d < 0) != (tt < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sat_s32(longint v);
		if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return -64'sh8000_0000;
		return v;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned res, one;
		res = 0;
		one = 64'd1 << 62;
		while (one > x) one = one >> 2;
		while (one != 0) begin
			if (x >= res + one) begin
				x = x - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	// closest point, parameter and distance for one request
	function automatic point_res_t closest(logic [31:0] f [9], logic seg);
		longint a [3], b [3], p [3], ab [3], c [3];
		logic signed [127:0] dot, x, y;
		logic [127:0] len2, dmag, q, s;
		longint t, diff;
		logic dneg, dg;
		point_res_t r;
		dot = 0;
		len2 = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'($signed(f[i]));
			b[i] = longint'($signed(f[3 + i]));
			p[i] = longint'($signed(f[6 + i]));
			ab[i] = b[i] - a[i];
			x = ab[i];
			y = p[i] - a[i];
			dot = dot + x * y;
			len2 = len2 + 128'(x * x);
			c[i] = a[i];
		end
		dneg = dot < 0;
		dmag = dneg ? 128'(-dot) : 128'(dot);
		dg = (len2 == 0);
		t = 0;
		if (!dg) begin
			q = (dmag << 16) / len2;
			if (q > 128'h8000_0000) q = 128'h8000_0000;
			if (seg) begin
				if (dneg || dmag == 0) begin
					t = 0;
				end else if (dmag >= len2) begin
					t = 64'h1_0000;
					for (int i = 0; i < 3; i++) c[i] = b[i];
				end else begin
					t = longint'(q);
				end
			end else if (dneg) begin
				t = -longint'(q);
			end else begin
				t = (q > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
			end
			if (!(seg && (dneg || dmag == 0 || dmag >= len2))) begin
				for (int i = 0; i < 3; i++) c[i] = sat_s32(a[i] + scale_q16(ab[i], t));
			end
		end
		s = 0;
		for (int i = 0; i < 3; i++) begin
			diff = p[i] - c[i];
			x = diff;
			s = s + 128'(x * x);
		end
		r.cx = c[0][31:0];
		r.cy = c[1][31:0];
		r.cz = c[2][31:0];
		r.t = t[31:0];
		if (s[127:64] != 0) begin
			r.dst = 32'hFFFF_FFFF;
		end else begin
			s[63:0] = isqrt(s[63:0]);
			r.dst = (s[63:32] != 0) ? 32'hFFFF_FFFF : s[31:0];
		end
		r.degen = dg;
		return r;
	endfunction

	task automatic report(string nm, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", nm, got, want, $time);
		errors++;
	endtask

	// accepted requests, configuration writes and results, all at the rising edge
	always @(posedge clk) begin
		point_res_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				seg_mode = cfg_data;
				cfg_cnt++;
			end
			if (pop && !empty) begin
				if (pending_q.size() == 0) begin
					$display("unexpected result at %0t", $time);
					errors++;
				end else begin
					w = pending_q.pop_front();
					if (c_x !== w.cx) report("c_x", c_x, w.cx);
					if (c_y !== w.cy) report("c_y", c_y, w.cy);
					if (c_z !== w.cz) report("c_z", c_z, w.cz);
					if (param_t !== w.t) report("param_t", param_t, w.t);
					if (distance !== w.dst) report("distance", distance, w.dst);
					if (degenerate !== w.degen) begin
						report("degenerate", 32'(degenerate), 32'(w.degen));
					end
				end
			end
			if (push && !full) begin
				pending_q.push_back(cur_typed ? cur_exp : closest(in_f, seg_mode));
				in_cnt++;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send(logic [31:0] f [9], logic typed, point_res_t e);
		int prev;
		if ($urandom_range(99) < tx_idle_pct) begin
			push = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_f = f;
		cur_typed = typed;
		cur_exp = e;
		push = 1'b1;
		prev = in_cnt;
		do @(negedge clk); while (in_cnt == prev);
		push = 1'b0;
	endtask

	// wait for the pipeline to drain, then write clamp_mode
	task automatic write_mode(logic v);
		int prev;
		push = 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		prev = cfg_cnt;
		do @(negedge clk); while (cfg_cnt == prev);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	task automatic add_row(logic [31:0] a0, a1, a2, b0, b1, b2, p0, p1, p2,
			logic typed, point_res_t e);
		stim_row_t r;
		r.f = '{a0, a1, a2, b0, b1, b2, p0, p1, p2};
		r.typed = typed;
		r.e = e;
		rows.push_back(r);
	endtask

	function automatic point_res_t mk(logic [31:0] x, y, z, t, d, logic dg);
		point_res_t r;
		r = '{x, y, z, t, d, dg};
		return r;
	endfunction

	task automatic run_random(int n);
		logic [31:0] f [9];
		point_res_t none;
		int sel;
		none = mk(0, 0, 0, 0, 0, 0);
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 9; i++) f[i] = rnd_coord();
			sel = 3 * $urandom_range(1);
			case ($urandom_range(9))
				// zero-length segment
				0: for (int i = 0; i < 3; i++) f[3 + i] = f[i];
				// query point at one end
				1: for (int i = 0; i < 3; i++) f[6 + i] = f[sel + i];
				// everything full range
				2: for (int i = 0; i < 9; i++) f[i] = $urandom;
				default: ;
			endcase
			send(f, 1'b0, none);
		end
	endtask

	localparam logic [31:0] Mx = 32'h7FFF_FFFF;
	localparam logic [31:0] Mn = 32'h8000_0000;
	localparam logic [31:0] One = 32'h0001_0000;
	localparam logic [31:0] MOne = 32'hFFFF_0000;

	initial begin
		point_res_t none;
		none = mk(0, 0, 0, 0, 0, 0);
		// zero-length segments
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, mk(0, 0, 0, 0, 0, 1));
		add_row(Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, 1, mk(Mx, Mx, Mx, 0, 0, 1));
		add_row(Mn, Mn, Mn, Mn, Mn, Mn, Mx, Mx, Mx, 0, none);
		add_row(0, 0, 0, 0, 0, 0, One, 0, 0, 1, mk(0, 0, 0, 0, One, 1));
		// before A and past B
		add_row(0, 0, 0, One, 0, 0, MOne, 0, 0, 1, mk(0, 0, 0, 0, One, 0));
		add_row(0, 0, 0, One, 0, 0, 32'h0002_0000, 0, 0, 1, mk(One, 0, 0, One, One, 0));
		add_row(0, 0, 0, One, 0, 0, 0, One, 0, 1, mk(0, 0, 0, 0, One, 0));
		add_row(0, 0, 0, 32'h0002_0000, 0, 0, One, One, 0, 0, none);
		// full-range extremes
		add_row(Mn, Mn, Mn, Mx, Mx, Mx, Mn, Mn, Mn, 1, mk(Mn, Mn, Mn, 0, 0, 0));
		add_row(Mn, Mn, Mn, Mx, Mx, Mx, Mx, Mx, Mx, 1, mk(Mx, Mx, Mx, One, 0, 0));
		add_row(Mn, Mn, Mn, Mx, Mx, Mx, 0, 0, 0, 0, none);
		add_row(Mn, Mx, Mn, Mx, Mn, Mx, Mx, Mn, Mn, 0, none);
		add_row(Mx, Mn, 0, Mn, Mx, 0, Mx, Mx, Mx, 0, none);
		add_row(0, 0, 0, 1, 0, 0, Mx, Mn, Mx, 0, none);
		add_row(32'hFFFF_FFFF, 0, 0, 1, 0, 0, 0, Mx, 0, 0, none);
		add_row(0, 0, 0, 1, 1, 1, Mx, Mx, Mx, 0, none);
		add_row(0, 0, 0, 1, 1, 1, Mn, Mn, Mn, 0, none);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows in segment mode, then again in line mode
		foreach (rows[i]) send(rows[i].f, rows[i].typed, rows[i].e);
		write_mode(1'b0);
		foreach (rows[i]) send(rows[i].f, 1'b0, none);

		tx_idle_pct = 22;
		rx_idle_pct = 62;
		run_random(200);
		write_mode(1'b1);
		tx_idle_pct = 62;
		rx_idle_pct = 22;
		run_random(200);
		write_mode(1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(100);
		write_mode(1'b1);
		run_random(100);

		while (pending_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0) begin
			$display("** segment_closest_point: PASSED **");
		end else begin
			$display("** segment_closest_point: FAILED **");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("** segment_closest_point: FAILED **");
		$finish;
	end

endmodule
